@@ src/smd_pkg.sv @@
package smd_pkg;

  localparam int unsigned NumChainWords = 5;
  localparam int unsigned NumBlockWords = 16;
  localparam int unsigned NumRounds     = 80;
  localparam int unsigned RoundsPerGrp  = 20;
  localparam int unsigned LenBytePos    = 56;

  localparam logic [7:0] PadMarker = 8'h80;

  localparam logic [31:0] RoundK [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  localparam logic [31:0] ChainInit [NumChainWords] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  typedef enum logic [1:0] {
    GRP_CHOOSE = 2'd0,
    GRP_PARITY = 2'd1,
    GRP_MAJOR  = 2'd2,
    GRP_PARLATE = 2'd3
  } round_grp_e;

  typedef enum logic [1:0] {
    PAD_MARK = 2'd0,
    PAD_ZERO = 2'd1,
    PAD_LEN  = 2'd2
  } pad_sel_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } smd_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } smd_out_t;

  typedef struct packed {
    logic       shift_msg;
    logic       shift_pad;
    pad_sel_e   pad_sel;
    logic       load_work;
    logic       round_en;
    round_grp_e grp;
    logic       add_chain;
    logic       init_chain;
    logic [2:0] word_sel;
  } smd_cmd_t;

  typedef struct packed {
    logic [5:0] pos;
  } smd_stat_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

endpackage

@@ src/smd_ctrl.sv @@
module smd_ctrl import smd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      has_byte_i,
  input  logic      end_of_message_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  smd_stat_t stat_i,
  output smd_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_MARK,
    ST_PAD_FILL,
    ST_PAD_TAIL,
    ST_ROUNDS,
    ST_ADD,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    RES_IDLE,
    RES_PAD_MARK,
    RES_PAD_TAIL,
    RES_OUT
  } resume_e;

  state_e     state_q, state_d;
  resume_e    resume_q, resume_d;
  logic [6:0] rnd_q, rnd_d;
  logic [2:0] word_q, word_d;

  logic pos_last;
  logic pos_tail;

  assign pos_last = (stat_i.pos == 6'd63);
  assign pos_tail = (stat_i.pos[5:3] == 3'(LenBytePos / 8));

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

  // Decode commands and next state
  always_comb begin
    state_d  = state_q;
    resume_d = resume_q;
    rnd_d    = rnd_q;
    word_d   = word_q;
    cmd_o    = '0;
    cmd_o.pad_sel  = PAD_ZERO;
    cmd_o.grp      = GRP_CHOOSE;
    cmd_o.word_sel = word_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.shift_msg = has_byte_i;
          if (has_byte_i && pos_last) begin
            cmd_o.load_work = 1'b1;
            rnd_d    = '0;
            state_d  = ST_ROUNDS;
            resume_d = end_of_message_i ? RES_PAD_MARK : RES_IDLE;
          end else if (end_of_message_i) begin
            state_d = ST_PAD_MARK;
          end
        end
      end
      ST_PAD_MARK: begin
        cmd_o.shift_pad = 1'b1;
        cmd_o.pad_sel   = PAD_MARK;
        if (pos_last) begin
          cmd_o.load_work = 1'b1;
          rnd_d    = '0;
          state_d  = ST_ROUNDS;
          resume_d = RES_PAD_TAIL;
        end else if (pos_tail) begin
          state_d = ST_PAD_FILL;
        end else begin
          state_d = ST_PAD_TAIL;
        end
      end
      ST_PAD_FILL: begin
        // zero out the block whose tail has no room for the length
        cmd_o.shift_pad = 1'b1;
        cmd_o.pad_sel   = PAD_ZERO;
        if (pos_last) begin
          cmd_o.load_work = 1'b1;
          rnd_d    = '0;
          state_d  = ST_ROUNDS;
          resume_d = RES_PAD_TAIL;
        end
      end
      ST_PAD_TAIL: begin
        cmd_o.shift_pad = 1'b1;
        cmd_o.pad_sel   = pos_tail ? PAD_LEN : PAD_ZERO;
        if (pos_last) begin
          cmd_o.load_work = 1'b1;
          rnd_d    = '0;
          state_d  = ST_ROUNDS;
          resume_d = RES_OUT;
        end
      end
      ST_ROUNDS: begin
        cmd_o.round_en = 1'b1;
        if (rnd_q < 7'(RoundsPerGrp)) begin
          cmd_o.grp = GRP_CHOOSE;
        end else if (rnd_q < 7'(2 * RoundsPerGrp)) begin
          cmd_o.grp = GRP_PARITY;
        end else if (rnd_q < 7'(3 * RoundsPerGrp)) begin
          cmd_o.grp = GRP_MAJOR;
        end else begin
          cmd_o.grp = GRP_PARLATE;
        end
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == 7'(NumRounds - 1)) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd_o.add_chain = 1'b1;
        case (resume_q)
          RES_IDLE:     state_d = ST_IDLE;
          RES_PAD_MARK: state_d = ST_PAD_MARK;
          RES_PAD_TAIL: state_d = ST_PAD_TAIL;
          default: begin
            word_d  = '0;
            state_d = ST_OUT;
          end
        endcase
      end
      ST_OUT: begin
        if (out_ready_i) begin
          if (word_q == 3'(NumChainWords - 1)) begin
            cmd_o.init_chain = 1'b1;
            word_d  = '0;
            state_d = ST_IDLE;
          end else begin
            word_d = word_q + 3'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      resume_q <= RES_IDLE;
      rnd_q    <= '0;
      word_q   <= '0;
    end else begin
      state_q  <= state_d;
      resume_q <= resume_d;
      rnd_q    <= rnd_d;
      word_q   <= word_d;
    end
  end

endmodule

@@ src/smd_datapath.sv @@
module smd_datapath import smd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] data_byte_i,
  input  smd_cmd_t   cmd_i,
  output smd_stat_t  stat_o,
  output smd_out_t   out_data_o
);

  logic [31:0] chain_q [NumChainWords];
  logic [31:0] w_q [NumBlockWords];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [63:0] bit_count_q;
  logic [5:0]  pos_q;

  logic [7:0]  pad_byte;
  logic [7:0]  in_byte;
  logic [5:0]  len_sh;
  logic [63:0] len_word;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] t_val;
  logic [31:0] w_new;
  logic [31:0] sel_word;

  assign stat_o.pos = pos_q;

  // Pick the byte to shift into the block
  assign len_sh   = {3'd7 - pos_q[2:0], 3'b000};
  assign len_word = bit_count_q >> len_sh;

  always_comb begin
    case (cmd_i.pad_sel)
      PAD_MARK: pad_byte = PadMarker;
      PAD_LEN:  pad_byte = len_word[7:0];
      default:  pad_byte = 8'h00;
    endcase
  end

  assign in_byte = cmd_i.shift_msg ? data_byte_i : pad_byte;

  // Round function for the current group
  always_comb begin
    case (cmd_i.grp)
      GRP_CHOOSE: f_val = (b_q & c_q) | (~b_q & d_q);
      GRP_MAJOR:  f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      default:    f_val = b_q ^ c_q ^ d_q;
    endcase
  end

  assign k_val = RoundK[cmd_i.grp];
  assign t_val = rotl(a_q, 5) + f_val + e_q + w_q[0] + k_val;
  assign w_new = rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);

  // Shift bytes in, or advance the schedule one word per round
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_msg || cmd_i.shift_pad) begin
      for (int i = 0; i < NumBlockWords - 1; i++) begin
        w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
      end
      w_q[NumBlockWords-1] <= {w_q[NumBlockWords-1][23:0], in_byte};
    end else if (cmd_i.round_en) begin
      for (int i = 0; i < NumBlockWords - 1; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[NumBlockWords-1] <= w_new;
    end
  end

  // Load or advance the working variables
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_work) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
      e_q <= chain_q[4];
    end else if (cmd_i.round_en) begin
      a_q <= t_val;
      b_q <= a_q;
      c_q <= rotl(b_q, 30);
      d_q <= c_q;
      e_q <= d_q;
    end
  end

  // Hold chaining value, bit count and block position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChainWords; i++) begin
        chain_q[i] <= ChainInit[i];
      end
      bit_count_q <= '0;
      pos_q       <= '0;
    end else begin
      if (cmd_i.init_chain) begin
        for (int i = 0; i < NumChainWords; i++) begin
          chain_q[i] <= ChainInit[i];
        end
        bit_count_q <= '0;
      end else if (cmd_i.add_chain) begin
        chain_q[0] <= chain_q[0] + a_q;
        chain_q[1] <= chain_q[1] + b_q;
        chain_q[2] <= chain_q[2] + c_q;
        chain_q[3] <= chain_q[3] + d_q;
        chain_q[4] <= chain_q[4] + e_q;
      end else if (cmd_i.shift_msg) begin
        bit_count_q <= bit_count_q + 64'd8;
      end
      if (cmd_i.shift_msg || cmd_i.shift_pad) begin
        pos_q <= pos_q + 6'd1;
      end
    end
  end

  // Select the digest word to present
  always_comb begin
    case (cmd_i.word_sel)
      3'd0:    sel_word = chain_q[0];
      3'd1:    sel_word = chain_q[1];
      3'd2:    sel_word = chain_q[2];
      3'd3:    sel_word = chain_q[3];
      default: sel_word = chain_q[4];
    endcase
  end

  assign out_data_o.digest_word = sel_word;
  assign out_data_o.word_index  = cmd_i.word_sel;
  assign out_data_o.last_word   = (cmd_i.word_sel == 3'(NumChainWords - 1));

endmodule

@@ src/sha1_message_digest_unit.sv @@
// SHA-1 digest, one message byte per request.
// A request that fills the 64-byte block starts 80 rounds on one
// shared round unit, then the chaining add.
// At message end, padding shifts one byte per cycle to block end, then rounds and add;
// a second padded block is shifted and compressed the same way; then five words out.
// Reset (async, active low) loads the initial chaining value and clears the count.
module sha1_message_digest_unit import smd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  smd_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output smd_out_t out_data_o
);

  smd_cmd_t  cmd;
  smd_stat_t stat;

  smd_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .has_byte_i       (in_data_i.has_byte),
    .end_of_message_i (in_data_i.end_of_message),
    .in_ready_o       (in_ready_o),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .stat_i           (stat),
    .cmd_o            (cmd)
  );

  smd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_byte_i (in_data_i.data_byte),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

endmodule

@@ test/sha1_message_digest_unit_tb.sv @@
`timescale 1ns / 100ps

module sha1_message_digest_unit_tb;
  import smd_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 300;
  localparam int unsigned RandomItems   = 400;

  localparam logic [7:0]  PadStartByte = 8'h80;
  localparam logic [31:0] ChainStart [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };
  localparam logic [31:0] RoundConst [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  // receiver behavior, picked anew at random intervals
  typedef enum int {
    RX_STREAM,
    RX_CHOPPY,
    RX_LONG_STALL
  } rx_mode_e;

  // Track the running SHA-1 state and hold the digest words still owed.
  class digest_scoreboard;
    logic [31:0] chain_words [5];
    logic [31:0] block_words [16];
    logic [63:0] msg_bits;
    smd_out_t    digest_queue [$];
    int unsigned mismatches;
    int unsigned words_checked;
    int unsigned messages_seen;

    function new();
      block_words = '{default: '0};
      mismatches = 0;
      words_checked = 0;
      messages_seen = 0;
      restart_message();
    endfunction

    function void restart_message();
      for (int i = 0; i < 5; i++) chain_words[i] = ChainStart[i];
      msg_bits = '0;
    endfunction

    function logic [31:0] rot_left(logic [31:0] x, int unsigned n);
      logic [63:0] twice;
      twice = {x, x} << n;
      return twice[63:32];
    endfunction

    // store one byte big-endian into its word
    function void place_byte(int unsigned pos, logic [7:0] b);
      int unsigned w;
      int unsigned sh;
      w = (pos >> 2) & 15;
      sh = (3 - (pos & 3)) * 8;
      block_words[w][sh +: 8] = b;
    endfunction

    // run the 80 rounds over the block and fold into the chain
    function void compress_block();
      logic [31:0] sched [80];
      logic [31:0] a, b, c, d, e, f, t;
      round_grp_e  grp;
      for (int i = 0; i < 16; i++) sched[i] = block_words[i];
      for (int i = 16; i < 80; i++)
        sched[i] = rot_left(sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16], 1);
      a = chain_words[0];
      b = chain_words[1];
      c = chain_words[2];
      d = chain_words[3];
      e = chain_words[4];
      for (int i = 0; i < 80; i++) begin
        grp = round_grp_e'(i / 20);
        case (grp)
          GRP_CHOOSE: f = (b & c) | (~b & d);
          GRP_MAJOR:  f = (b & c) | (b & d) | (c & d);
          default:    f = b ^ c ^ d;
        endcase
        t = rot_left(a, 5) + f + e + sched[i] + RoundConst[i / 20];
        e = d;
        d = c;
        c = rot_left(b, 30);
        b = a;
        a = t;
      end
      chain_words[0] += a;
      chain_words[1] += b;
      chain_words[2] += c;
      chain_words[3] += d;
      chain_words[4] += e;
    endfunction

    // absorb one accepted request; on end of message pad and queue the digest
    function void note_request(smd_in_t req);
      int unsigned pos;
      smd_out_t    word;
      if (req.has_byte) begin
        pos = msg_bits[8:3];
        place_byte(pos, req.data_byte);
        msg_bits += 64'd8;
        if (pos == 63) compress_block();
      end
      if (!req.end_of_message) return;
      pos = msg_bits[8:3];
      place_byte(pos, PadStartByte);
      pos++;
      // length field does not fit: close this block first
      if (pos > 56) begin
        for (int unsigned i = pos; i < 64; i++) place_byte(i, 8'h00);
        compress_block();
        pos = 0;
      end
      for (int unsigned i = pos; i < 56; i++) place_byte(i, 8'h00);
      block_words[14] = msg_bits[63:32];
      block_words[15] = msg_bits[31:0];
      compress_block();
      for (int i = 0; i < 5; i++) begin
        word.digest_word = chain_words[i];
        word.word_index  = 3'(i);
        word.last_word   = (i == 4);
        digest_queue.push_back(word);
      end
      messages_seen++;
      restart_message();
    endfunction

    function void check_result(smd_out_t got);
      smd_out_t want;
      if (digest_queue.size() == 0) begin
        $display("%0t: unexpected digest word %h (index %0d, last %0b)",
                 $time, got.digest_word, got.word_index, got.last_word);
        mismatches++;
        return;
      end
      want = digest_queue.pop_front();
      words_checked++;
      if (got.digest_word !== want.digest_word) begin
        $display("%0t: digest_word expected %h actual %h",
                 $time, want.digest_word, got.digest_word);
        mismatches++;
      end
      if (got.word_index !== want.word_index) begin
        $display("%0t: word_index expected %0d actual %0d",
                 $time, want.word_index, got.word_index);
        mismatches++;
      end
      if (got.last_word !== want.last_word) begin
        $display("%0t: last_word expected %0b actual %0b",
                 $time, want.last_word, got.last_word);
        mismatches++;
      end
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  smd_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  smd_out_t out_data_o;

  digest_scoreboard sb = new();

  logic [7:0]  msg_bytes [$];
  int unsigned burst_left;
  int unsigned items_sent;
  int unsigned bytes_sent;
  int unsigned idle_sent;
  int unsigned idle_cycles;
  int unsigned stall_left;
  int unsigned mode_left;
  rx_mode_e    rx_mode;

  sha1_message_digest_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // free-running clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // stall the digest output on a pattern that changes over time
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      mode_left = $urandom_range(50, 300);
    end else begin
      mode_left--;
    end
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (rx_mode == RX_CHOPPY && $urandom_range(0, 99) < 40) begin
      out_ready_i <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else if (rx_mode == RX_LONG_STALL && $urandom_range(0, 99) < 10) begin
      out_ready_i <= 1'b0;
      stall_left = $urandom_range(5, 40);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // check each digest word taken; end the run if traffic stops
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // hold one request until taken, opening a gap between bursts
  task automatic send_request(input smd_in_t req);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 16);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(req);
    burst_left--;
  endtask

  // request with neither byte nor end, which the block drops
  task automatic send_idle_item();
    smd_in_t req;
    req.data_byte = 8'($urandom_range(0, 255));
    req.has_byte = 1'b0;
    req.end_of_message = 1'b0;
    send_request(req);
    idle_sent++;
  endtask

  // send msg_bytes as one message; the last byte may ride on the end request
  task automatic send_message(input bit end_carries_byte, input int unsigned noise_pct);
    smd_in_t     req;
    int unsigned body;
    bit          carry;
    carry = end_carries_byte && (msg_bytes.size() > 0);
    body = carry ? msg_bytes.size() - 1 : msg_bytes.size();
    for (int unsigned i = 0; i < body; i++) begin
      if ($urandom_range(0, 99) < noise_pct) send_idle_item();
      req.data_byte = msg_bytes[i];
      req.has_byte = 1'b1;
      req.end_of_message = 1'b0;
      send_request(req);
      items_sent++;
    end
    req.data_byte = carry ? msg_bytes[body] : 8'($urandom_range(0, 255));
    req.has_byte = carry;
    req.end_of_message = 1'b1;
    send_request(req);
    items_sent++;
    bytes_sent += msg_bytes.size();
  endtask

  initial begin
    int unsigned len;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    burst_left = 0;
    items_sent = 0;
    bytes_sent = 0;
    idle_sent = 0;
    idle_cycles = 0;
    stall_left = 0;
    mode_left = 0;
    rx_mode = RX_STREAM;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: dropped requests, empty messages, short messages, byte extremes
    send_idle_item();
    msg_bytes = {};
    send_message(1'b0, 0);
    msg_bytes = '{8'h61, 8'h62, 8'h63};
    send_message(1'b1, 0);
    msg_bytes = '{8'h00, 8'hFF};
    send_message(1'b0, 0);
    send_idle_item();
    msg_bytes = '{8'hFF};
    send_message(1'b1, 0);
    msg_bytes = {};
    send_message(1'b1, 0);
    msg_bytes = '{8'h5A, 8'hC3};
    send_message(1'b0, 100);

    // random messages, weighted toward the padding boundaries
    while (items_sent < RandomItems) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: len = $urandom_range(0, 8);
        4, 5, 6: begin
          case ($urandom_range(0, 9))
            0: len = 55;
            1: len = 56;
            2: len = 57;
            3: len = 63;
            4: len = 64;
            5: len = 65;
            6: len = 119;
            7: len = 120;
            8: len = 127;
            default: len = 128;
          endcase
        end
        default: len = $urandom_range(0, 130);
      endcase
      msg_bytes = {};
      repeat (len) msg_bytes.push_back(8'($urandom_range(0, 255)));
      send_message($urandom_range(0, 1), ($urandom_range(0, 2) == 0) ? 0 : 10);
    end
    in_valid_i <= 1'b0;

    // drain the digest words still owed, then allow for stray output
    while (sb.digest_queue.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d messages, %0d message bytes, %0d dropped requests",
             sb.messages_seen, bytes_sent, idle_sent);
    $display("compared %0d digest words, %0d mismatches", sb.words_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
